>>> hw/rtl/pfs_pkg.sv
`default_nettype none

package pfs_pkg;

  localparam int VALUE_BITS = 16;
  localparam int INSERT_BITS = 16;

  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INSERT_VALUE = 1'b1;

  localparam int MODE_BITS = 2;
  localparam logic [MODE_BITS-1:0] MODE_ZERO = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd2;

  function automatic int div_count(input int vb);
    longint max_val;
    longint d;
    int c;
    max_val = (longint'(1) << (vb - 1)) - 1;
    c = 0;
    for (d = 3; d * d <= max_val; d = d + 2) begin
      c = c + 1;
    end
    return c;
  endfunction

  localparam int DIV_COUNT = div_count(VALUE_BITS);
  localparam int IDX_BITS = $clog2(DIV_COUNT);
  localparam int TAB_DEPTH = 1 << IDX_BITS;
  localparam int DIV_MAX = 2 * DIV_COUNT + 1;
  localparam int DIV_BITS = $clog2(DIV_MAX + 3);
  localparam int SQ_BITS = 2 * DIV_BITS;

  typedef logic [TAB_DEPTH-1:0][VALUE_BITS-1:0] inv_tab_t;

  function automatic inv_tab_t build_inv();
    inv_tab_t t;
    logic [63:0] x;
    logic [63:0] d;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      d = 64'(2 * i + 3);
      x = d;
      for (int k = 0; k < 6; k++) begin
        x = x * (64'd2 - d * x);
      end
      t[i] = x[VALUE_BITS-1:0];
    end
    return t;
  endfunction

  localparam inv_tab_t INV_TAB = build_inv();

  typedef struct packed {
    logic [VALUE_BITS-1:0] element;
    logic                  array_end;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] out_value;
    logic                  has_value;
    logic                  out_array_end;
    logic                  run_last;
  } result_t;

  typedef enum logic [2:0] {
    EMIT_PASS,
    EMIT_ZERO,
    EMIT_END_ONLY,
    EMIT_FIRST,
    EMIT_INSERT
  } emit_kind_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       emit;
    emit_kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic                 lt2;
    logic                 two;
    logic                 even;
    logic                 bound_ok;
    logic                 hit;
    logic                 pend;
    logic                 end_flag;
    logic [MODE_BITS-1:0] mode;
  } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/prime_filter_stream.sv
// Flow: values below 3, even values and 3, 5, 7 are decided without trying a divisor; else
// odd divisors are tried in turn until one divides or the square bound is passed (one per
// cycle, at most 90 for 16-bit values); a mode-2 prime shows its inserted value in the next
// cycle. A new item is not taken while busy; start is taken again in the cycle the last result
// is shown. The receiver cannot stall, one strobe each.
// Reset (rst, synchronous): control idles, mode and insert_value return to 0.
`default_nettype none

module prime_filter_stream (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  pfs_pkg::in_item_t                    item,
  output logic                                 result_valid,
  output pfs_pkg::result_t                     result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pfs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [pfs_pkg::INSERT_BITS-1:0]      cfg_data
);
  import pfs_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  pfs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .busy  (busy),
    .cmd   (cmd)
  );

  pfs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .st           (st),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

>>> hw/rtl/pfs_datapath.sv
`default_nettype none

module pfs_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pfs_pkg::in_item_t                    item,
  input  logic                                 cfg_valid,
  input  logic [pfs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [pfs_pkg::INSERT_BITS-1:0]      cfg_data,
  input  pfs_pkg::cmd_t                        cmd,
  output pfs_pkg::status_t                     st,
  output logic                                 result_valid,
  output pfs_pkg::result_t                     result
);
  import pfs_pkg::*;

  localparam int PROD_BITS = VALUE_BITS + DIV_BITS;
  localparam int CMP_BITS = VALUE_BITS + SQ_BITS;

  logic [MODE_BITS-1:0]          mode;
  logic signed [INSERT_BITS-1:0] insert_value;

  logic [VALUE_BITS-1:0] v;
  logic                  end_flag;
  logic [IDX_BITS-1:0]   idx;
  logic [DIV_BITS-1:0]   d;
  logic [DIV_BITS-1:0]   d_chk;
  logic [SQ_BITS-1:0]    sq;
  logic [VALUE_BITS-1:0] q;
  logic                  pend;

  logic [VALUE_BITS-1:0] q_next;
  logic [PROD_BITS-1:0]  prod;
  logic                  bound_ok;
  logic                  hit;
  result_t               result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_ZERO;
      insert_value <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_MODE) begin
        mode <= cfg_data[MODE_BITS-1:0];
      end else begin
        insert_value <= cfg_data;
      end
    end
  end

  assign q_next   = v * INV_TAB[idx];
  assign prod     = PROD_BITS'(q) * PROD_BITS'(d_chk);
  assign hit      = pend && (prod == PROD_BITS'(v));
  assign bound_ok = CMP_BITS'(sq) <= CMP_BITS'(v);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.load) begin
      pend <= 1'b0;
    end else if (cmd.step) begin
      pend <= bound_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v        <= item.element;
      end_flag <= item.array_end;
      idx      <= '0;
      d        <= DIV_BITS'(3);
      sq       <= SQ_BITS'(9);
    end else if (cmd.step && bound_ok) begin
      q     <= q_next;
      d_chk <= d;
      d     <= d + DIV_BITS'(2);
      sq    <= sq + SQ_BITS'({d, 2'b00}) + SQ_BITS'(4);
      idx   <= idx + IDX_BITS'(1);
    end
  end

  always_comb begin
    st.lt2      = v[VALUE_BITS-1] | (v < VALUE_BITS'(2));
    st.two      = (v == VALUE_BITS'(2));
    st.even     = ~v[0];
    st.bound_ok = bound_ok;
    st.hit      = hit;
    st.pend     = pend;
    st.end_flag = end_flag;
    st.mode     = mode;
  end

  always_comb begin
    result_next.out_value     = v;
    result_next.has_value     = 1'b1;
    result_next.out_array_end = end_flag;
    result_next.run_last      = 1'b1;
    unique case (cmd.kind)
      EMIT_PASS: begin
      end
      EMIT_ZERO: begin
        result_next.out_value = '0;
      end
      EMIT_END_ONLY: begin
        result_next.out_value     = '0;
        result_next.has_value     = 1'b0;
        result_next.out_array_end = 1'b1;
      end
      EMIT_FIRST: begin
        result_next.out_array_end = 1'b0;
        result_next.run_last      = 1'b0;
      end
      EMIT_INSERT: begin
        result_next.out_value = VALUE_BITS'(insert_value);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pfs_ctrl.sv
`default_nettype none

module pfs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  pfs_pkg::status_t st,
  output logic             busy,
  output pfs_pkg::cmd_t    cmd
);
  import pfs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_TEST = 3'b010,
    ST_INS  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   pass_now;
  logic   prime_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    pass_now  = st.lt2 || (st.even && !st.two) || (!st.two && st.hit);
    prime_now = st.two || (!st.hit && !st.bound_ok && !st.pend);
  end

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.emit   = 1'b0;
    cmd.kind   = EMIT_PASS;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_TEST;
        end
      end
      ST_TEST: begin
        cmd.step = 1'b1;
        priority if (pass_now) begin
          cmd.emit   = 1'b1;
          cmd.kind   = EMIT_PASS;
          state_next = ST_IDLE;
        end else if (prime_now) begin
          state_next = ST_IDLE;
          unique case (st.mode)
            MODE_ZERO: begin
              cmd.emit = 1'b1;
              cmd.kind = EMIT_ZERO;
            end
            MODE_DELETE: begin
              cmd.emit = st.end_flag;
              cmd.kind = EMIT_END_ONLY;
            end
            MODE_INSERT: begin
              cmd.emit   = 1'b1;
              cmd.kind   = EMIT_FIRST;
              state_next = ST_INS;
            end
            default: begin
              cmd.emit = 1'b1;
              cmd.kind = EMIT_PASS;
            end
          endcase
        end else begin
        end
      end
      ST_INS: begin
        cmd.emit   = 1'b1;
        cmd.kind   = EMIT_INSERT;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/pfs_checker.sv
`default_nettype none

module pfs_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             result_valid,
  input pfs_pkg::result_t result
);
  import pfs_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_first_then_insert: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.run_last |=> result_valid && result.run_last)
    else $error("first result of a pair not followed by its second");

  a_first_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.run_last |-> result.has_value && !result.out_array_end && busy)
    else $error("first result of a pair malformed");

  a_end_only: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.has_value |-> result.out_array_end && result.run_last)
    else $error("end-only result without end and last marks");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.run_last |-> !busy)
    else $error("busy while last result of an item is shown");

endmodule

bind prime_filter_stream pfs_checker u_pfs_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

`default_nettype wire
